// ===== design/dda_line_rasterizer_core_defines.svh =====
// Assertion macros shared by the rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DDA_LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dlr_pkg.sv =====
package dlr_pkg;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int COLOUR_W   = 4;
  localparam logic [COLOUR_W-1:0] COLOUR_RESET = COLOUR_W'(4);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_W-1:0]      acc_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WALK
  } dlr_state_t;

  // request to the slope divider
  typedef struct packed {
    logic   start;
    coord_t numer;
    coord_t denom;
  } dlr_div_req_t;

  // divider response
  typedef struct packed {
    logic done;
    acc_t quot;
  } dlr_div_rsp_t;

endpackage

// ===== design/dlr_slope_div.sv =====
// Restoring divider: (numer << FRAC_BITS) / denom, one quotient bit per cycle.
module dlr_slope_div
  import dlr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dlr_div_req_t req,
  output dlr_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ACC_W);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  acc_t               q_r, q_nxt;
  coord_t             rem_r, rem_nxt;
  coord_t             den_r, den_nxt;
  logic               done_r;

  logic [COORD_BITS:0] trial;
  logic                fits;

  always_comb begin
    trial = {rem_r, q_r[ACC_W-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ACC_W - 1);
      q_nxt    = {req.numer, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      den_nxt  = req.denom;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in COORD_BITS
      rem_nxt = fits ? coord_t'(trial - {1'b0, den_r}) : trial[COORD_BITS-1:0];
      q_nxt   = {q_r[ACC_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // done: the last bit has just been shifted in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0) && !req.start;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== design/dda_line_rasterizer_core.sv =====
// Channel  Dir  tdata fields (low bit up)                    side band
// in_      in   start_x, start_y, end_x, end_y (24 bits)     -
// out_     out  pixel_x, pixel_y, colour_out (16 bits)       tlast = last_pixel
// cfg_     in   pixel_colour (4 bits)                        write enable only
//
// A segment is accepted, its slope is computed in the slope divider, then it is
// walked at one pixel per cycle (1..64 pixels) while out_ is not stalled.
// in_tready is high only while no segment is being divided or walked.
// A stalled out_ channel holds the walk; the pixel in the output register waits.
// Synchronous active-low reset; pixel_colour resets to 4.
`include "dda_line_rasterizer_core_defines.svh"

module dda_line_rasterizer_core
  import dlr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_x, pixel_y, colour_out
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  dlr_state_t state_r, state_nxt;

  logic [COLOUR_W-1:0] colour_r;
  coord_t major_pos_r, major_pos_nxt;
  coord_t major_end_r, major_end_nxt;
  acc_t   acc_r, acc_nxt;
  acc_t   slope_r, slope_nxt;
  logic   major_is_y_r, major_is_y_nxt;
  logic   step_up_r, step_up_nxt;
  logic   neg_r, neg_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  dlr_div_req_t div_req;
  dlr_div_rsp_t div_rsp;

  dlr_slope_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // endpoint ordering and spans
  coord_t ax, ay, bx, by, ix0, iy0, ix1, iy1, dx, ady;
  logic   swap, y_major;
  always_comb begin
    ix0  = in_tdata[5:0];
    iy0  = in_tdata[11:6];
    ix1  = in_tdata[17:12];
    iy1  = in_tdata[23:18];
    swap = (ix1 < ix0) || ((ix1 == ix0) && (iy1 < iy0));
    ax   = swap ? ix1 : ix0;
    ay   = swap ? iy1 : iy0;
    bx   = swap ? ix0 : ix1;
    by   = swap ? iy0 : iy1;
    dx   = bx - ax;
    ady  = (by >= ay) ? (by - ay) : (ay - by);
    y_major = (ady > dx);
  end

  logic   in_fire, pix_load, is_last;
  coord_t minor;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign pix_load  = (state_r == S_WALK) && (!out_valid_r || out_tready);
  assign minor     = acc_r[ACC_W-1:FRAC_BITS];
  assign is_last   = (major_pos_r == major_end_r);

  always_comb begin
    state_nxt      = state_r;
    major_pos_nxt  = major_pos_r;
    major_end_nxt  = major_end_r;
    acc_nxt        = acc_r;
    slope_nxt      = slope_r;
    major_is_y_nxt = major_is_y_r;
    step_up_nxt    = step_up_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    div_req.start  = 1'b0;
    div_req.numer  = y_major ? dx : ady;
    div_req.denom  = y_major ? ady : dx;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          div_req.start  = 1'b1;
          major_is_y_nxt = y_major;
          major_pos_nxt  = y_major ? ay : ax;
          major_end_nxt  = y_major ? by : bx;
          acc_nxt        = {(y_major ? ax : ay), {FRAC_BITS{1'b0}}};
          step_up_nxt    = y_major ? (by > ay) : 1'b1;
          neg_nxt        = !y_major && (by < ay);
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          slope_nxt = neg_r ? (~div_rsp.quot + ACC_W'(1)) : div_rsp.quot;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (pix_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = major_is_y_r ? {colour_r, major_pos_r, minor}
                                       : {colour_r, minor, major_pos_r};
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            major_pos_nxt = step_up_r ? (major_pos_r + COORD_BITS'(1))
                                      : (major_pos_r - COORD_BITS'(1));
            acc_nxt       = acc_r + slope_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      colour_r    <= COLOUR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        colour_r <= cfg_wdata;
      end
    end
    major_pos_r  <= major_pos_nxt;
    major_end_r  <= major_end_nxt;
    acc_r        <= acc_nxt;
    slope_r      <= slope_nxt;
    major_is_y_r <= major_is_y_nxt;
    step_up_r    <= step_up_nxt;
    neg_r        <= neg_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DLR_ASSERT_NEXT(a_accept_busy, in_fire, !in_tready, "accepted segment did not drop ready")
  `DLR_ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == S_DIV, "divider done outside divide")
  `DLR_ASSERT_NEXT(a_last_idle, pix_load && is_last, in_tready && out_tvalid && out_tlast,
                   "last pixel did not end the walk")
  `DLR_ASSERT_NOW(a_walk_no_start, state_r != S_IDLE, !div_req.start, "divider restarted mid-segment")

endmodule
